// File: hdl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, codes and constants of the reply frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int          REPLY_BUF_BYTES_DEF = 1024;
    localparam logic [15:0] MAGIC_WORD_A        = 16'h5050;
    localparam logic [15:0] MAGIC_WORD_B        = 16'h7d82;
    localparam logic [31:0] HEADER_BYTES        = 32'd8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_SINK_ENABLED  = 1'b0;
    localparam logic REG_DATA_CMD_CODE = 1'b1;

    localparam logic [15:0] DATA_CMD_RESET = 16'd1501;

    typedef enum logic [1:0] {
        PH_TOP = 2'd0,
        PH_HDR = 2'd1,
        PH_PAY = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_HDR   = 3'd0,
        ST_SINK  = 3'd1,
        ST_KEPT  = 3'd2,
        ST_DROP  = 3'd3,
        ST_MAGIC = 3'd4,
        ST_SHORT = 3'd5
    } status_t;

    typedef struct packed {
        logic        sink_enabled;
        logic [15:0] data_cmd_code;
    } rfd_cfg_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  data_byte;
        logic [9:0]  reply_index;
        logic [15:0] frame_cmd;
        logic [15:0] frame_tag;
        logic [15:0] sess_word;
        logic [10:0] kept_len;
        logic        frame_end;
    } rfd_result_t;

    // expected magic byte at top-block position 0..3
    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = MAGIC_WORD_A[7:0];
            2'd1:    b = MAGIC_WORD_A[15:8];
            2'd2:    b = MAGIC_WORD_B[7:0];
            default: b = MAGIC_WORD_B[15:8];
        endcase
        return b;
    endfunction

endpackage

// File: hdl/rfd_cfg.sv
// ----------------------------------------------------------------------------
// rfd_cfg
// APB register file: sink enable and data command code.
// ----------------------------------------------------------------------------
module rfd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output rfd_pkg::rfd_cfg_t              cfg
);
    import rfd_pkg::*;

    logic        sink_enabled_reg;
    logic [15:0] data_cmd_code_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_enabled_reg  <= 1'b0;
            data_cmd_code_reg <= DATA_CMD_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_SINK_ENABLED:  sink_enabled_reg  <= pwdata[0];
                REG_DATA_CMD_CODE: data_cmd_code_reg <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SINK_ENABLED:  prdata = {31'b0, sink_enabled_reg};
            REG_DATA_CMD_CODE: prdata = {16'b0, data_cmd_code_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.sink_enabled  = sink_enabled_reg;
    assign cfg.data_cmd_code = data_cmd_code_reg;

endmodule

// File: hdl/rfd_step.sv
// ----------------------------------------------------------------------------
// rfd_step
// Frame state and the per-byte decode: top block check, header capture,
// payload routing. Result is combinational from the registered input byte.
// ----------------------------------------------------------------------------
module rfd_step #(
    parameter int REPLY_BUF_BYTES = rfd_pkg::REPLY_BUF_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [7:0]            rx_byte,
    input  logic                  clear_session,
    input  rfd_pkg::rfd_cfg_t     cfg,
    output rfd_pkg::rfd_result_t  result
);
    import rfd_pkg::*;

    localparam int KEPT_W = $clog2(REPLY_BUF_BYTES + 1);

    phase_t              phase_reg,        phase_next;
    logic [2:0]          field_count_reg,  field_count_next;
    logic                magic_good_reg,   magic_good_next;
    logic [31:0]         frame_length_reg, frame_length_next;
    logic [15:0]         cmd_word_reg,     cmd_word_next;
    logic [15:0]         reply_word_reg,   reply_word_next;
    logic [15:0]         session_word_reg, session_word_next;
    logic [7:0]          session_low_reg,  session_low_next;
    logic [31:0]         payload_left_reg, payload_left_next;
    logic                to_sink_reg,      to_sink_next;
    logic [KEPT_W-1:0]   kept_count_reg,   kept_count_next;

    logic [15:0]         session_base;
    logic                magic_match;
    logic                magic_base;
    logic [31:0]         payload_dec;
    logic                buf_room;
    logic [KEPT_W+10:0]  kept_ext;
    logic [KEPT_W+10:0]  index_ext;
    status_t             status;
    logic [7:0]          data_byte;
    logic                frame_end;

    assign session_base = clear_session ? 16'd0 : session_word_reg;
    assign magic_match  = (rx_byte == magic_byte(field_count_reg[1:0]));
    assign magic_base   = (field_count_reg == 3'd0) ? 1'b1 : magic_good_reg;
    assign payload_dec  = payload_left_reg - 32'd1;
    assign buf_room     = (kept_count_reg < KEPT_W'(REPLY_BUF_BYTES));

    // top-block byte insert into the length word
    always_comb
    begin
        frame_length_next = frame_length_reg;
        if (phase_reg != PH_HDR && phase_reg != PH_PAY && field_count_reg[2])
        begin
            case (field_count_reg[1:0])
                2'd0:    frame_length_next[7:0]   = rx_byte;
                2'd1:    frame_length_next[15:8]  = rx_byte;
                2'd2:    frame_length_next[23:16] = rx_byte;
                default: frame_length_next[31:24] = rx_byte;
            endcase
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HDR:
            begin
                if (field_count_reg == 3'd7)
                    phase_next = (frame_length_reg == HEADER_BYTES) ? PH_TOP : PH_PAY;
            end
            PH_PAY:
            begin
                if (payload_dec == 32'd0)
                    phase_next = PH_TOP;
            end
            default:
            begin
                phase_next = PH_TOP;
                if (field_count_reg == 3'd7 && magic_good_next
                    && frame_length_next >= HEADER_BYTES)
                    phase_next = PH_HDR;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        field_count_next  = field_count_reg;
        magic_good_next   = magic_good_reg;
        cmd_word_next     = cmd_word_reg;
        reply_word_next   = reply_word_reg;
        session_word_next = session_base;
        session_low_next  = session_low_reg;
        payload_left_next = payload_left_reg;
        to_sink_next      = to_sink_reg;
        kept_count_next   = kept_count_reg;
        status            = ST_HDR;
        data_byte         = 8'd0;
        index_ext         = '0;
        frame_end         = 1'b0;

        unique case (phase_reg)
            PH_HDR:
            begin
                field_count_next = field_count_reg + 3'd1;
                case (field_count_reg)
                    3'd0: cmd_word_next = {8'd0, rx_byte};
                    3'd1: cmd_word_next = {rx_byte, cmd_word_reg[7:0]};
                    3'd4: session_low_next = rx_byte;
                    3'd5:
                    begin
                        if (session_base == 16'd0)
                            session_word_next = {rx_byte, session_low_reg};
                    end
                    3'd6: reply_word_next = {8'd0, rx_byte};
                    3'd7: reply_word_next = {rx_byte, reply_word_reg[7:0]};
                    default: ;
                endcase
                if (field_count_reg == 3'd7)
                begin
                    kept_count_next   = '0;
                    to_sink_next      = cfg.sink_enabled
                                        && (cmd_word_reg == cfg.data_cmd_code);
                    payload_left_next = frame_length_reg - HEADER_BYTES;
                    frame_end         = (frame_length_reg == HEADER_BYTES);
                end
            end
            PH_PAY:
            begin
                payload_left_next = payload_dec;
                frame_end         = (payload_dec == 32'd0);
                if (to_sink_reg)
                begin
                    status    = ST_SINK;
                    data_byte = rx_byte;
                end
                else if (buf_room)
                begin
                    status          = ST_KEPT;
                    data_byte       = rx_byte;
                    index_ext       = {11'd0, kept_count_reg};
                    kept_count_next = kept_count_reg + KEPT_W'(1);
                end
                else
                begin
                    status = ST_DROP;
                end
            end
            default:
            begin
                field_count_next = field_count_reg + 3'd1;
                if (!field_count_reg[2])
                    magic_good_next = magic_base && magic_match;
                else if (field_count_reg == 3'd0)
                    magic_good_next = 1'b1;
                if (field_count_reg == 3'd7)
                begin
                    if (!magic_good_reg)
                    begin
                        status    = ST_MAGIC;
                        frame_end = 1'b1;
                    end
                    else if (frame_length_next < HEADER_BYTES)
                    begin
                        status    = ST_SHORT;
                        frame_end = 1'b1;
                    end
                end
            end
        endcase
    end

    assign kept_ext = {11'd0, kept_count_next};

    assign result.status      = status;
    assign result.data_byte   = data_byte;
    assign result.reply_index = index_ext[9:0];
    assign result.frame_cmd   = cmd_word_next;
    assign result.frame_tag   = reply_word_next;
    assign result.sess_word   = session_word_next;
    assign result.kept_len    = kept_ext[10:0];
    assign result.frame_end   = frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TOP;
            field_count_reg  <= 3'd0;
            magic_good_reg   <= 1'b1;
            frame_length_reg <= 32'd0;
            cmd_word_reg     <= 16'd0;
            reply_word_reg   <= 16'd0;
            session_word_reg <= 16'd0;
            session_low_reg  <= 8'd0;
            payload_left_reg <= 32'd0;
            to_sink_reg      <= 1'b0;
            kept_count_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg        <= phase_next;
            field_count_reg  <= field_count_next;
            magic_good_reg   <= magic_good_next;
            frame_length_reg <= frame_length_next;
            cmd_word_reg     <= cmd_word_next;
            reply_word_reg   <= reply_word_next;
            session_word_reg <= session_word_next;
            session_low_reg  <= session_low_next;
            payload_left_reg <= payload_left_next;
            to_sink_reg      <= to_sink_next;
            kept_count_reg   <= kept_count_next;
        end
    end

endmodule

// File: hdl/reply_frame_deframer_unit.sv
// rx transfers load the input register; the result register loads from it when out_free
// throughput: one byte per cycle, limited only by the result handshake
// one result per byte; the input and result registers decouple the two sides
// reset: rst_n clears the frame state to the top block, session id to zero,
// sink mode off and the data command code to 1501
// ----------------------------------------------------------------------------
// reply_frame_deframer_unit
// Byte stream deframer: input register, per-byte decode, result register.
// ----------------------------------------------------------------------------
module reply_frame_deframer_unit #(
    parameter int REPLY_BUF_BYTES = rfd_pkg::REPLY_BUF_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           rx_valid,
    output logic                           rx_ready,
    input  logic [7:0]                     rx_byte,
    input  logic                           clear_session,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [2:0]                     status,
    output logic [7:0]                     data_byte,
    output logic [9:0]                     reply_index,
    output logic [15:0]                    frame_cmd,
    output logic [15:0]                    frame_tag,
    output logic [15:0]                    sess_word,
    output logic [10:0]                    kept_len,
    output logic                           frame_end
);
    import rfd_pkg::*;

    rfd_cfg_t    cfg;
    rfd_result_t step_result;
    rfd_result_t res_reg;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_clear_reg;
    logic        res_valid_reg, res_valid_next;
    logic        out_free;
    logic        step_en;
    logic        rx_take;

    rfd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfd_step #(
        .REPLY_BUF_BYTES (REPLY_BUF_BYTES)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .rx_byte       (in_byte_reg),
        .clear_session (in_clear_reg),
        .cfg           (cfg),
        .result        (step_result)
    );

    assign out_free = !res_valid_reg || res_ready;
    assign rx_ready = !in_valid_reg || out_free;
    assign rx_take  = rx_valid && rx_ready;
    assign step_en  = in_valid_reg && out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_take)
            in_valid_next = 1'b1;
        else if (out_free)
            in_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (step_en)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_byte_reg  <= rx_byte;
            in_clear_reg <= clear_session;
        end
        if (step_en)
            res_reg <= step_result;
    end

    assign res_valid   = res_valid_reg;
    assign status      = res_reg.status;
    assign data_byte   = res_reg.data_byte;
    assign reply_index = res_reg.reply_index;
    assign frame_cmd   = res_reg.frame_cmd;
    assign frame_tag   = res_reg.frame_tag;
    assign sess_word   = res_reg.sess_word;
    assign kept_len    = res_reg.kept_len;
    assign frame_end   = res_reg.frame_end;

    // errors always close the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_MAGIC || status == ST_SHORT) |-> frame_end)
        else $error("error result without frame_end");

    // a kept byte advances the reply length by one past its index
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_KEPT |-> kept_len[9:0] == reply_index + 10'd1)
        else $error("reply length out of step with reply index");

    // only sink and kept bytes carry payload data
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_SINK && status != ST_KEPT |-> data_byte == 8'd0)
        else $error("payload byte on a non-payload result");

endmodule
